// File: rtl/nfb_pkg.sv
// ----------------------------------------------------------------------------
// nfb_pkg
// shared types and constants of the nor flash byte store
// ----------------------------------------------------------------------------
package nfb_pkg;

	localparam int unsigned FLASH_BYTES_DEF = 64 * 1024;
	localparam int unsigned PAGE_BYTES_DEF  = 4096;

	localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
	localparam logic [31:0] BASE_AT_RESET = 32'h0007_0000;

	typedef enum logic [1:0] {
		CMD_READ       = 2'd0,
		CMD_WRITE      = 2'd1,
		CMD_PAGE_ERASE = 2'd2,
		CMD_CHIP_ERASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RMW,
		ST_SWEEP
	} seq_state_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] address;
		logic [7:0]  write_byte;
		logic        final_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       in_range;
		logic       access_done;
	} rsp_t;

	typedef logic [31:0] cfg_t;

	// memory port controls
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// sequencer to top level
	typedef struct packed {
		logic rsp_load;
		logic busy;
	} seq_status_t;

endpackage

// File: rtl/nfb_stream_if.sv
// ----------------------------------------------------------------------------
// nfb_stream_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface nfb_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/nor_flash_byte_store.sv
// ----------------------------------------------------------------------------
// nor_flash_byte_store
// nor flash array model with byte read, AND write, page and chip erase
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        accepted when
//  cfg      in   flash_base (32 bits)                           valid && ready
//  req      in   command, address, write_byte, final_byte       valid && ready
//  rsp      out  read_byte, in_range, access_done               valid && ready
//
//  read and write items do a memory read; the write-back and result load then wait for a free output slot
//  an in-range page erase then sweeps its page, chip erase the whole array (one byte a cycle)
//  after reset a clearing pass fills the whole array with 0xFF
//  a finished result waits in the output register; a new item is taken meanwhile,
//  and only its completion waits for the register to empty
// ----------------------------------------------------------------------------
module nor_flash_byte_store import nfb_pkg::*; #(
	parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF,  // 4096 .. 16M
	parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF    // power of two, 16 .. 64k
) (
	input  logic          clk,
	input  logic          arst_n,
	nfb_stream_if.sink    cfg,
	nfb_stream_if.sink    req,
	nfb_stream_if.source  rsp
);

	localparam int unsigned AW = $clog2(FLASH_BYTES);

	// base address register, always writable
	logic [31:0] base_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	seq_status_t   status;
	rsp_t          result;
	mem_ctl_t      mem_ctl;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic          slot_free;

	assign cfg.ready = 1'b1;
	// output slot frees when empty or being taken this cycle
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_AT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				base_q <= cfg.data;
			end
			if (status.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (status.rsp_load) begin
			rsp_q <= result;
		end
	end

	// sequencer: range check, read-modify-write, erase sweeps
	nfb_seq #(
		.FLASH_BYTES (FLASH_BYTES),
		.PAGE_BYTES  (PAGE_BYTES),
		.AW          (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.flash_base (base_q),
		.slot_free  (slot_free),
		.status     (status),
		.result     (result),
		.mem_ctl    (mem_ctl),
		.mem_raddr  (mem_raddr),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	// flash array
	nfb_mem #(
		.DEPTH (FLASH_BYTES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.raddr (mem_raddr),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		status.rsp_load |-> (!rsp_valid_q || rsp.ready))
		else $error("result loaded over a pending one");

	// one item at a time: after an accept the sequencer is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (!req.ready && status.busy))
		else $error("item accepted while previous one still in work");

	// memory is never read while the sequencer is busy
	a_no_read_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !mem_ctl.rd_en)
		else $error("memory read issued while busy");
`endif

endmodule

// File: rtl/nfb_mem.sv
// ----------------------------------------------------------------------------
// nfb_mem
// byte array, one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module nfb_mem import nfb_pkg::*; #(
	parameter int unsigned DEPTH = FLASH_BYTES_DEF,
	parameter int unsigned AW    = $clog2(FLASH_BYTES_DEF)
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] raddr,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/nfb_seq.sv
// ----------------------------------------------------------------------------
// nfb_seq
// item sequencer: range check, read-modify-write and erase sweeps
// ----------------------------------------------------------------------------
module nfb_seq import nfb_pkg::*; #(
	parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF,
	parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
	parameter int unsigned AW          = $clog2(FLASH_BYTES_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	nfb_stream_if.sink    req,
	input  logic [31:0]   flash_base,
	input  logic          slot_free,
	output seq_status_t   status,
	output rsp_t          result,
	output mem_ctl_t      mem_ctl,
	output logic [AW-1:0] mem_raddr,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	input  logic [7:0]    mem_rdata
);

	localparam logic [31:0]   SIZE32    = 32'(FLASH_BYTES);
	localparam logic [31:0]   LAST32    = 32'(FLASH_BYTES - 1);
	localparam logic [AW-1:0] LAST_IDX  = AW'(FLASH_BYTES - 1);
	localparam logic [31:0]   PAGE_SPAN = 32'(PAGE_BYTES);
	localparam logic [31:0]   PAGE_MASK = ~(PAGE_SPAN - 32'd1);

	seq_state_t state_q, state_d;

	cmd_t          cmd_s1;
	logic [AW-1:0] off_s1;
	logic [7:0]    wbyte_s1;
	logic          hit_s1;
	logic          last_s1;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] end_q;

	logic [31:0] offset;
	logic        hit;
	logic        accept;
	logic        to_sweep;
	logic [31:0] page_first;
	logic [31:0] page_last;

	assign offset = req.data.address - flash_base;
	assign hit    = offset < SIZE32;
	assign accept = req.valid && req.ready;

	// page bounds, last page cut off at the end of the array
	assign page_first = {{(32-AW){1'b0}}, off_s1} & PAGE_MASK;
	always_comb begin
		page_last = page_first + PAGE_SPAN - 32'd1;
		if (page_last > LAST32) begin
			page_last = LAST32;
		end
	end

	assign to_sweep = (cmd_s1 == CMD_CHIP_ERASE) || ((cmd_s1 == CMD_PAGE_ERASE) && hit_s1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_RMW;
				end
			end
			ST_RMW: begin
				if (slot_free) begin
					state_d = to_sweep ? ST_SWEEP : ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (cnt_q == end_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready       = 1'b0;
		mem_ctl         = '0;
		mem_raddr       = offset[AW-1:0];
		mem_waddr       = off_s1;
		mem_wdata       = mem_rdata & wbyte_s1;
		status.rsp_load = 1'b0;
		status.busy     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req.ready     = 1'b1;
				status.busy   = 1'b0;
				mem_ctl.rd_en = req.valid;
			end
			ST_RMW: begin
				status.rsp_load = slot_free;
				mem_ctl.wr_en   = slot_free && (cmd_s1 == CMD_WRITE) && hit_s1;
			end
			ST_SWEEP: begin
				mem_ctl.wr_en = 1'b1;
				mem_waddr     = cnt_q;
				mem_wdata     = ERASED_BYTE;
			end
			default: ;
		endcase
	end

	always_comb begin
		result.read_byte   = ((cmd_s1 == CMD_READ) && hit_s1) ? mem_rdata : ERASED_BYTE;
		result.in_range    = hit_s1;
		result.access_done = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			cnt_q   <= '0;
			end_q   <= LAST_IDX;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RMW && slot_free && to_sweep) begin
				if (cmd_s1 == CMD_CHIP_ERASE) begin
					cnt_q <= '0;
					end_q <= LAST_IDX;
				end else begin
					cnt_q <= page_first[AW-1:0];
					end_q <= page_last[AW-1:0];
				end
			end else if (state_q == ST_SWEEP) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.data.command;
			off_s1   <= offset[AW-1:0];
			wbyte_s1 <= req.data.write_byte;
			hit_s1   <= hit;
			last_s1  <= req.data.final_byte;
		end
	end

endmodule
